/* rtl/core/utm_pkg.sv */
// ---------------------------------------------------------------------------
// utm_pkg: shared types and constants of the UTF-8 text extent measurer
// Glyph table size, function and status codes, controller states and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none
package utm_pkg;

  localparam int unsigned TABLE_ENTRIES = 128;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned CODE_W = 21;
  localparam int unsigned ADV_W  = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] SCALE_RESET       = 16'd256;
  localparam logic [CFG_W-1:0] LINE_HEIGHT_RESET = 16'd614;

  localparam logic [7:0] LEAD1_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] CONT_BITS  = 8'h3F;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_BITS = 8'h07;
  localparam logic [CODE_W-1:0] LINE_FEED = 21'd10;

  typedef enum logic [1:0] {
    FUNC_STORE  = 2'd0,
    FUNC_BYTE   = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  localparam logic [1:0] STAT_STORED = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_MEAS   = 2'd2;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_STORED,
    RES_FULL,
    RES_MEAS,
    RES_EMPTY
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DECODE,
    ST_TAKE,
    ST_RD,
    ST_CMP,
    ST_FMAX,
    ST_MUL,
    ST_REPORT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic key_partial;
    logic scan_start;
    logic idx_inc;
    logic write_hit;
    logic write_new;
    logic add_adv;
    logic newline;
    logic fmax;
    logic mul;
    logic clear_text;
    res_t res;
    logic emit;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  glyph_zero;
    logic  cp_done;
    logic  key_nl;
    logic  scan_end;
    logic  hit;
    logic  full;
    logic  any_seen;
    logic  pending_nz;
    logic  out_busy;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/utm_if.sv */
// ---------------------------------------------------------------------------
// utm_if: valid/ready channels of the text extent measurer
// Input channel carries one command beat, output channel one result beat.
// ---------------------------------------------------------------------------
`default_nettype none
interface utm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic [20:0] glyph_codepoint;
  logic [15:0] glyph_advance;
  modport source (output valid, func, data_byte, glyph_codepoint, glyph_advance,
                  input ready);
  modport sink   (input valid, func, data_byte, glyph_codepoint, glyph_advance,
                  output ready);
endinterface

interface utm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] text_width;
  logic [31:0] text_height;
  logic [15:0] line_total;
  modport source (output valid, status, text_width, text_height, line_total,
                  input ready);
  modport sink   (input valid, status, text_width, text_height, line_total,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/utm_text_extent_top.sv */
// ---------------------------------------------------------------------------
// utf8_text_extent_measurer: UTF-8 text extent measurer, top level
// Glyph advance table plus lenient UTF-8 decode and scaled extent report.
// ---------------------------------------------------------------------------
`default_nettype none
module utf8_text_extent_measurer (
  input  wire logic clk,
  input  wire logic rst_n,
  utm_in_if.sink    in_ch,
  utm_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [utm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [utm_pkg::CFG_W-1:0] cfg_wdata
);
  // channel  | dir | beat contents
  // in_ch    | in  | func, data_byte, glyph_codepoint, glyph_advance
  // out_ch   | out | status, text_width, text_height, line_total
  // cfg_*    | in  | write enable, index (0 scale, 1 line height), data
  //
  // One beat is worked on at a time. A text byte that leaves its codepoint open
  // only updates the decoder, and a newline closes the line with no table scan; any
  // other closed codepoint scans the glyph table one entry at a time (registered
  // read, then compare) over the entries in use. A store scans the same way; a
  // finish first scans a partial codepoint if one is open, then scales and reports.
  // Reset clears control and text state; the table has a fill count, so no
  // clearing pass is needed. The output register holds a result while the
  // sink stalls; the next beat is still taken and waits only to hand over.
  import utm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  utm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  utm_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_func            (in_ch.func),
    .in_data_byte       (in_ch.data_byte),
    .in_glyph_codepoint (in_ch.glyph_codepoint),
    .in_glyph_advance   (in_ch.glyph_advance),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_text_width     (out_ch.text_width),
    .out_text_height    (out_ch.text_height),
    .out_line_total     (out_ch.line_total)
  );

endmodule
`default_nettype wire

/* rtl/core/utm_dp.sv */
// ---------------------------------------------------------------------------
// utm_dp: datapath of the text extent measurer
// Glyph table memory, UTF-8 decode, line accumulation, scaling, result regs.
// ---------------------------------------------------------------------------
`default_nettype none
module utm_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [20:0] in_glyph_codepoint,
  input  wire logic [15:0] in_glyph_advance,
  input  wire logic cfg_we,
  input  wire logic [utm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [utm_pkg::CFG_W-1:0] cfg_wdata,
  input  wire utm_pkg::cmd_t cmd,
  output utm_pkg::sts_t sts,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_text_width,
  output logic [31:0] out_text_height,
  output logic [15:0] out_line_total
);
  import utm_pkg::*;

  logic [CFG_W-1:0] scale_r, lheight_r;
  func_t func_r;
  logic [7:0] byte_r;
  logic [CODE_W-1:0] key_r;
  logic [ADV_W-1:0] adv_r;

  logic [CODE_W-1:0] code_mem [TABLE_ENTRIES];
  logic [ADV_W-1:0]  adv_mem  [TABLE_ENTRIES];
  logic [CODE_W-1:0] code_q;
  logic [ADV_W-1:0]  adv_q;
  logic [CNT_W-1:0]  idx_r, used_r;

  logic [1:0] pend_r;
  logic [CODE_W-1:0] partial_r;
  logic [31:0] cur_r, widest_r, h1_r;
  logic [15:0] lines_r;
  logic any_r;
  logic [47:0] pw_r, ph_r;

  logic [1:0] res_status_r;
  logic [31:0] res_w_r, res_h_r;
  logic [15:0] res_n_r;
  logic out_valid_r;

  logic [CODE_W-1:0] cont, merged, dec_partial, dec_cp;
  logic [1:0] dec_pend;
  logic dec_done;
  logic [32:0] sum;
  logic [IDX_W-1:0] wr_addr;

  always_comb begin
    cont = {15'd0, byte_r[5:0] & CONT_BITS[5:0]};
    case (pend_r)
      2'd1:    merged = partial_r | cont;
      2'd2:    merged = partial_r | (cont << 6);
      default: merged = partial_r | (cont << 12);
    endcase
    dec_partial = partial_r;
    dec_cp = '0;
    dec_pend = pend_r;
    dec_done = 1'b0;
    if (pend_r != 2'd0) begin
      dec_pend = pend_r - 2'd1;
      if (dec_pend == 2'd0) begin
        dec_done = 1'b1;
        dec_cp = merged;
        dec_partial = '0;
      end else begin
        dec_partial = merged;
      end
    end else if ((byte_r & LEAD1_MASK) == 8'h00) begin
      dec_done = 1'b1;
      dec_cp = {13'd0, byte_r};
    end else if ((byte_r & LEAD2_MASK) == LEAD2_VAL) begin
      dec_partial = {10'd0, byte_r[4:0] & LEAD2_BITS[4:0], 6'd0};
      dec_pend = 2'd1;
    end else if ((byte_r & LEAD3_MASK) == LEAD2_MASK) begin
      dec_partial = {5'd0, byte_r[3:0] & LEAD3_BITS[3:0], 12'd0};
      dec_pend = 2'd2;
    end else if ((byte_r & LEAD4_MASK) == LEAD3_MASK) begin
      dec_partial = {byte_r[2:0] & LEAD4_BITS[2:0], 18'd0};
      dec_pend = 2'd3;
    end else begin
      dec_done = 1'b1;
      dec_cp = '0;
    end
  end

  assign sum = {1'b0, cur_r} + {17'd0, adv_q};
  assign wr_addr = cmd.write_new ? used_r[IDX_W-1:0] : idx_r[IDX_W-1:0];

  // glyph table memory
  always_ff @(posedge clk) begin
    if (cmd.write_new) begin
      code_mem[wr_addr] <= key_r;
    end
    if (cmd.write_new || cmd.write_hit) begin
      adv_mem[wr_addr] <= adv_r;
    end
    code_q <= code_mem[idx_r[IDX_W-1:0]];
    adv_q  <= adv_mem[idx_r[IDX_W-1:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_data_byte;
      key_r  <= in_glyph_codepoint;
      adv_r  <= in_glyph_advance;
    end else if (cmd.decode) begin
      key_r <= dec_cp;
    end else if (cmd.key_partial) begin
      key_r <= partial_r;
    end
    if (cmd.fmax) begin
      h1_r <= lines_r * lheight_r;
    end
    if (cmd.mul) begin
      pw_r <= widest_r * scale_r;
      ph_r <= h1_r * scale_r;
    end
    case (cmd.res)
      RES_STORED, RES_FULL: begin
        res_status_r <= (cmd.res == RES_FULL) ? STAT_FULL : STAT_STORED;
        res_w_r <= '0;
        res_h_r <= '0;
        res_n_r <= '0;
      end
      RES_MEAS: begin
        res_status_r <= STAT_MEAS;
        res_w_r <= (|pw_r[47:40]) ? '1 : pw_r[39:8];
        res_h_r <= (|ph_r[47:40]) ? '1 : ph_r[39:8];
        res_n_r <= lines_r;
      end
      RES_EMPTY: begin
        res_status_r <= STAT_MEAS;
        res_w_r <= '0;
        res_h_r <= '0;
        res_n_r <= '0;
      end
      default: ;
    endcase
    if (cmd.emit) begin
      out_status      <= res_status_r;
      out_text_width  <= res_w_r;
      out_text_height <= res_h_r;
      out_line_total  <= res_n_r;
    end
  end

  // control and text state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCALE_RESET;
      lheight_r   <= LINE_HEIGHT_RESET;
      func_r      <= FUNC_NONE;
      idx_r       <= '0;
      used_r      <= '0;
      pend_r      <= '0;
      partial_r   <= '0;
      cur_r       <= '0;
      widest_r    <= '0;
      lines_r     <= 16'd1;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_SCALE) begin
        scale_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_LINE_HEIGHT) begin
        lheight_r <= cfg_wdata;
      end
      if (cmd.load) begin
        func_r <= func_t'(in_func);
      end
      if (cmd.scan_start) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.write_new) begin
        used_r <= used_r + 1'b1;
      end
      if (cmd.decode) begin
        pend_r    <= dec_pend;
        partial_r <= dec_partial;
        any_r     <= 1'b1;
      end
      if (cmd.add_adv) begin
        cur_r <= sum[32] ? '1 : sum[31:0];
      end
      if (cmd.newline) begin
        if (cur_r > widest_r) begin
          widest_r <= cur_r;
        end
        cur_r <= '0;
        if (lines_r != 16'hFFFF) begin
          lines_r <= lines_r + 16'd1;
        end
      end
      if (cmd.fmax && cur_r > widest_r) begin
        widest_r <= cur_r;
      end
      if (cmd.clear_text) begin
        pend_r    <= '0;
        partial_r <= '0;
        cur_r     <= '0;
        widest_r  <= '0;
        lines_r   <= 16'd1;
        any_r     <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.func       = func_r;
    sts.glyph_zero = (key_r == '0);
    sts.cp_done    = dec_done;
    sts.key_nl     = (key_r == LINE_FEED);
    sts.scan_end   = (idx_r == used_r);
    sts.hit        = (code_q == key_r);
    sts.full       = (used_r == CNT_W'(TABLE_ENTRIES));
    sts.any_seen   = any_r;
    sts.pending_nz = (pend_r != 2'd0);
    sts.out_busy   = out_valid_r && !out_ready;
  end

endmodule
`default_nettype wire

/* rtl/core/utm_ctrl.sv */
// ---------------------------------------------------------------------------
// utm_ctrl: controller of the text extent measurer
// Sequences decode, table scan, line bookkeeping, scaling and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none
module utm_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire utm_pkg::sts_t sts,
  output utm_pkg::cmd_t cmd
);
  import utm_pkg::*;

  state_t state_r, state_nxt, after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.res = RES_HOLD;
    in_ready = 1'b0;
    state_nxt = state_r;
    // finish resumes with the report, a text byte returns to idle
    after = (sts.func == FUNC_FINISH) ? ST_FMAX : ST_IDLE;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.func)
          FUNC_STORE: begin
            if (sts.glyph_zero) begin
              state_nxt = ST_IDLE;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt = ST_RD;
            end
          end
          FUNC_BYTE: state_nxt = ST_DECODE;
          FUNC_FINISH: begin
            if (!sts.any_seen) begin
              cmd.res = RES_EMPTY;
              cmd.clear_text = 1'b1;
              state_nxt = ST_OUT;
            end else if (sts.pending_nz) begin
              cmd.key_partial = 1'b1;
              state_nxt = ST_TAKE;
            end else begin
              state_nxt = ST_FMAX;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt = sts.cp_done ? ST_TAKE : ST_IDLE;
      end
      ST_TAKE: begin
        if (sts.key_nl) begin
          cmd.newline = 1'b1;
          state_nxt = after;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (sts.scan_end) begin
          if (sts.func == FUNC_STORE) begin
            if (sts.full) begin
              cmd.res = RES_FULL;
            end else begin
              cmd.write_new = 1'b1;
              cmd.res = RES_STORED;
            end
            state_nxt = ST_OUT;
          end else begin
            state_nxt = after;
          end
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.hit) begin
          if (sts.func == FUNC_STORE) begin
            cmd.write_hit = 1'b1;
            cmd.res = RES_STORED;
            state_nxt = ST_OUT;
          end else begin
            cmd.add_adv = 1'b1;
            state_nxt = after;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_FMAX: begin
        cmd.fmax = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.res = RES_MEAS;
        cmd.clear_text = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* tb/sv/tb_utf8_text_extent_measurer.sv */
// ---------------------------------------------------------------------------
// tb_utf8_text_extent_measurer: self-checking bench of the text extent measurer
// Loads glyph entries, streams UTF-8 text and finish commands with random
// gaps and back-pressure, predicts every result beat and compares it field
// by field against what the block emits.
// ---------------------------------------------------------------------------
module tb_utf8_text_extent_measurer;
  import utm_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic [20:0] cp;
    logic [15:0] adv;
  } cmd_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] w;
    logic [31:0] h;
    logic [15:0] n;
  } res_beat_t;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  utm_in_if  in_ch();
  utm_out_if out_ch();

  utf8_text_extent_measurer uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cmd_beat_t cmd_q[$];
  res_beat_t meas_q[$];
  int errors = 0;
  int cycles = 0;
  int random_cmds;
  bit hold_tx = 1'b0;

  // Predictor state: a mirror of the glyph table and the text accumulators
  logic [15:0] p_scale = SCALE_RESET;
  logic [15:0] p_lh = LINE_HEIGHT_RESET;
  bit          g_valid[TABLE_ENTRIES];
  logic [20:0] g_code[TABLE_ENTRIES];
  logic [15:0] g_adv[TABLE_ENTRIES];
  int unsigned t_pend = 0;
  logic [20:0] t_part = '0;
  logic [31:0] t_cur = '0;
  logic [31:0] t_widest = '0;
  logic [15:0] t_lines = 16'd1;
  bit          t_any = 1'b0;
  int          g_used = 0;

  task automatic clear_text_state();
    t_pend = 0; t_part = '0; t_cur = '0; t_widest = '0;
    t_lines = 16'd1; t_any = 1'b0;
  endtask

  task automatic add_codepoint(input logic [20:0] c);
    logic [32:0] s;
    if (c == LINE_FEED) begin
      if (t_cur > t_widest) t_widest = t_cur;
      t_cur = '0;
      if (t_lines != 16'hFFFF) t_lines++;
      return;
    end
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (g_valid[k] && g_code[k] == c) begin
        s = {1'b0, t_cur} + g_adv[k];
        t_cur = s[32] ? 32'hFFFF_FFFF : s[31:0];
        return;
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    t_any = 1'b1;
    if (t_pend != 0) begin
      t_part = t_part | (21'(b & CONT_BITS) << (6 * (t_pend - 1)));
      t_pend--;
      if (t_pend == 0) begin
        add_codepoint(t_part);
        t_part = '0;
      end
    end else if ((b & LEAD1_MASK) == 0) add_codepoint(21'(b));
    else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
      t_part = 21'(b & LEAD2_BITS) << 6; t_pend = 1;
    end else if ((b & LEAD3_MASK) == LEAD2_MASK) begin
      t_part = 21'(b & LEAD3_BITS) << 12; t_pend = 2;
    end else if ((b & LEAD4_MASK) == LEAD3_MASK) begin
      t_part = 21'(b & LEAD4_BITS) << 18; t_pend = 3;
    end else add_codepoint('0);
  endtask

  // Work out the result beat (if any) that one accepted command causes
  task automatic predict_extent(input cmd_beat_t c);
    res_beat_t r;
    logic [63:0] w, h;
    bit hit;
    r = '0;
    case (func_t'(c.func))
      FUNC_STORE: begin
        if (c.cp == 0) return;
        hit = 1'b0;
        r.status = STAT_FULL;
        for (int k = 0; k < TABLE_ENTRIES && !hit; k++)
          if (g_valid[k] && g_code[k] == c.cp) begin
            g_adv[k] = c.adv; hit = 1'b1; r.status = STAT_STORED;
          end
        for (int k = 0; k < TABLE_ENTRIES && !hit; k++)
          if (!g_valid[k]) begin
            g_valid[k] = 1'b1; g_code[k] = c.cp; g_adv[k] = c.adv;
            g_used++; hit = 1'b1; r.status = STAT_STORED;
          end
        meas_q.push_back(r);
      end
      FUNC_BYTE: decode_byte(c.data_byte);
      FUNC_FINISH: begin
        r.status = STAT_MEAS;
        if (t_any) begin
          if (t_pend != 0) add_codepoint(t_part);
          if (t_cur > t_widest) t_widest = t_cur;
          w = (64'(t_widest) * p_scale) >> 8;
          h = (64'(t_lines) * p_lh * p_scale) >> 8;
          r.w = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
          r.h = (h > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : h[31:0];
          r.n = t_lines;
        end
        meas_q.push_back(r);
        clear_text_state();
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: present queued beats, hold each until accepted, insert gaps
  int tx_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the beat
    end else begin
      if (in_ch.valid) tx_gap = pick_gap();
      if (tx_gap > 0 || hold_tx || cmd_q.size() == 0) begin
        if (tx_gap > 0) tx_gap--;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid           <= 1'b1;
        in_ch.func            <= cmd_q[0].func;
        in_ch.data_byte       <= cmd_q[0].data_byte;
        in_ch.glyph_codepoint <= cmd_q[0].cp;
        in_ch.glyph_advance   <= cmd_q[0].adv;
        void'(cmd_q.pop_front());
      end
    end
  end

  // Predict on acceptance of an input beat
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      predict_extent({in_ch.func, in_ch.data_byte, in_ch.glyph_codepoint,
                      in_ch.glyph_advance});
  end

  // Monitor: random back-pressure, compare each accepted result beat
  int rx_gap = 0;
  always @(posedge clk) begin
    res_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (meas_q.size() == 0) begin
        report_mismatch("unexpected beat, status", 32'(out_ch.status), 32'd0);
      end else begin
        want = meas_q.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
        if (out_ch.text_width !== want.w)
          report_mismatch("text_width", out_ch.text_width, want.w);
        if (out_ch.text_height !== want.h)
          report_mismatch("text_height", out_ch.text_height, want.h);
        if (out_ch.line_total !== want.n)
          report_mismatch("line_total", 32'(out_ch.line_total), 32'(want.n));
      end
    end
    if (rx_gap > 0) begin
      rx_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      rx_gap = pick_gap();
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_cmd(input logic [1:0] f, input logic [7:0] b,
                          input logic [20:0] c, input logic [15:0] a);
    cmd_q.push_back({f, b, c, a});
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_cmd(FUNC_BYTE, b, 21'($urandom), 16'($urandom));
  endtask

  // Let every queued beat go and every expected result come back
  task automatic drain();
    while (cmd_q.size() != 0 || in_ch.valid || meas_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SCALE) p_scale = v; else p_lh = v;
  endtask

  // Codepoints kept in the table so random text often hits
  logic [20:0] known_cp[$];

  // Encode one codepoint as a lead byte and continuation bytes, length picked from its size
  task automatic push_utf8(input logic [20:0] c);
    if (c < 21'h80) push_byte(8'(c));
    else if (c < 21'h800) begin
      push_byte(8'hC0 | 8'(c >> 6)); push_byte(8'h80 | 8'(c & 21'h3F));
    end else if (c < 21'h10000) begin
      push_byte(8'hE0 | 8'(c >> 12)); push_byte(8'h80 | 8'((c >> 6) & 21'h3F));
      push_byte(8'h80 | 8'(c & 21'h3F));
    end else begin
      push_byte(8'hF0 | 8'(c >> 18)); push_byte(8'h80 | 8'((c >> 12) & 21'h3F));
      push_byte(8'h80 | 8'((c >> 6) & 21'h3F)); push_byte(8'h80 | 8'(c & 21'h3F));
    end
  endtask

  task automatic random_phase(input int count);
    int r;
    logic [20:0] c;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        c = ($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'($urandom_range(1, 300));
        push_cmd(FUNC_STORE, 8'($urandom), c, 16'($urandom));
        known_cp.push_back(c);
      end else if (r < 65 && known_cp.size() > 0)
        push_utf8(known_cp[$urandom_range(0, known_cp.size() - 1)]);
      else if (r < 75) push_byte(8'h0A);
      else if (r < 88) push_byte(8'($urandom));
      else if (r < 97) push_cmd(FUNC_FINISH, 8'($urandom), 21'($urandom), 16'($urandom));
      else push_cmd(FUNC_NONE, 8'($urandom), 21'($urandom), 16'($urandom));
    end
    push_cmd(FUNC_FINISH, 8'($urandom), 21'($urandom), 16'($urandom));
  endtask

  initial begin
    for (int k = 0; k < TABLE_ENTRIES; k++) g_valid[k] = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_NONE;
    in_ch.data_byte = '0;
    in_ch.glyph_codepoint = '0;
    in_ch.glyph_advance = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty text, zero store, store/overwrite, extremes, odd forms
    push_cmd(FUNC_FINISH, 8'h00, 21'h0, 16'h0);
    push_cmd(FUNC_STORE, 8'h00, 21'h0, 16'h1234);
    push_cmd(FUNC_STORE, 8'hFF, 21'h41, 16'h0080);
    push_cmd(FUNC_STORE, 8'h00, 21'h41, 16'h00A0);
    push_cmd(FUNC_STORE, 8'h00, 21'h1FFFFF, 16'hFFFF);
    push_cmd(FUNC_STORE, 8'h00, 21'h0E9, 16'h0070);
    push_cmd(FUNC_NONE, 8'hFF, 21'h1FFFFF, 16'hFFFF);
    push_byte(8'h41); push_byte(8'hC3); push_byte(8'hA9);
    push_byte(8'hC0); push_byte(8'h8A);              // overlong newline
    push_byte(8'hFF); push_byte(8'h80);              // bad lead bytes
    push_byte(8'hF7); push_byte(8'hBF); push_byte(8'hBF); push_byte(8'hBF);
    push_cmd(FUNC_FINISH, 8'h00, 21'h0, 16'h0);
    push_byte(8'hE2); push_byte(8'h82);              // truncated at finish
    push_cmd(FUNC_FINISH, 8'h00, 21'h0, 16'h0);
    drain();

    // Extreme settings, widest line built from a repeated widest glyph
    write_cfg(CFG_SCALE, 16'hFFFF);
    write_cfg(CFG_LINE_HEIGHT, 16'hFFFF);
    known_cp.push_back(21'h41);
    known_cp.push_back(21'h0E9);
    known_cp.push_back(21'h1FFFFF);
    for (int i = 0; i < 6; i++) push_utf8(21'h1FFFFF);
    push_byte(8'h0A);
    push_cmd(FUNC_FINISH, 8'h00, 21'h0, 16'h0);
    drain();
    write_cfg(CFG_SCALE, 16'h0000);
    write_cfg(CFG_LINE_HEIGHT, 16'h0000);
    random_phase(30);
    drain();

    // Hold the sender off until every result is back, then resume
    write_cfg(CFG_SCALE, 16'h0100);
    write_cfg(CFG_LINE_HEIGHT, 16'h0266);
    random_phase(40);
    hold_tx = 1'b1;
    random_phase(10);
    while (in_ch.valid || meas_q.size() != 0) @(posedge clk);
    hold_tx = 1'b0;
    drain();

    // Fill the table past capacity to hit the full status
    for (int k = 0; k < TABLE_ENTRIES + 4; k++)
      push_cmd(FUNC_STORE, 8'h00, 21'(k + 1000), 16'($urandom));
    for (int k = 0; k < 8; k++) known_cp.push_back(21'(k + 1000));
    drain();

    for (int p = 0; p < 3; p++) begin
      write_cfg(CFG_SCALE, 16'($urandom));
      write_cfg(CFG_LINE_HEIGHT, 16'($urandom));
      random_phase(20);
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/utm_pkg.sv
rtl/core/utm_if.sv
rtl/core/utm_dp.sv
rtl/core/utm_ctrl.sv
rtl/core/utm_text_extent_top.sv
tb/sv/tb_utf8_text_extent_measurer.sv
